### src/cbw_pkg.sv
// ----------------------------------------------------------------------------
// cbw_pkg: shared types and constants of the cbor item walker
// byte roles, major types, error codes, walk phases and stack control structs
// ----------------------------------------------------------------------------
package cbw_pkg;

    localparam int NEST_DEPTH_DEF = 16;

    // additional-information thresholds in the head byte
    localparam logic [4:0] ADD_ONE_BYTE  = 5'd24;
    localparam logic [4:0] ADD_RESERVED  = 5'd28;

    // major types
    localparam logic [2:0] MAJ_BSTR  = 3'd2;
    localparam logic [2:0] MAJ_TSTR  = 3'd3;
    localparam logic [2:0] MAJ_ARRAY = 3'd4;
    localparam logic [2:0] MAJ_MAP   = 3'd5;
    localparam logic [2:0] MAJ_TAG   = 3'd6;

    // byte roles
    localparam logic [2:0] ROLE_HEAD     = 3'd0;
    localparam logic [2:0] ROLE_ARG      = 3'd1;
    localparam logic [2:0] ROLE_CONTENT  = 3'd2;
    localparam logic [2:0] ROLE_TRAILING = 3'd3;
    localparam logic [2:0] ROLE_IGNORED  = 3'd4;

    // error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_TAG       = 3'd1;
    localparam logic [2:0] ERR_RESERVED  = 3'd2;
    localparam logic [2:0] ERR_TRUNCATED = 3'd3;
    localparam logic [2:0] ERR_TOO_DEEP  = 3'd4;

    typedef enum logic [4:0] {
        PH_HEAD    = 5'b00001,
        PH_ARG     = 5'b00010,
        PH_CONTENT = 5'b00100,
        PH_TRAIL   = 5'b01000,
        PH_ERROR   = 5'b10000
    } phase_t;

    // stack control, one transfer per cycle at most
    typedef struct packed {
        logic push;      // open a container at the current level
        logic push_map;  // container being opened is a map
        logic close;     // one child item finished
        logic flush;     // final byte: back to empty
    } stack_ctrl_t;

    typedef struct packed {
        logic full;      // all levels in use
        logic done;      // close reached the top-level item
    } stack_stat_t;

endpackage

### src/cbor_item_walker.sv
// ----------------------------------------------------------------------------
// cbor_item_walker: walks one top-level cbor data item, one byte per transfer
// classifies each byte, decodes heads and tracks arrays and maps on a stack
// ----------------------------------------------------------------------------
// each transfer's result is registered into the output register as it is taken
// throughput: one byte per cycle while m_tready holds; the byte's decode, the
//   head handling and the stack pop cascade all settle in the cycle it is taken
// reset: rst_n clears the walk state, error and stack level; cell contents are
//   only read after a push writes them. the final byte also returns to reset
module cbor_item_walker #(
    parameter int NEST_DEPTH = cbw_pkg::NEST_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tlast,    // last_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,    // [63:0] head_value, [68:64] nest_level,
                                    // [71:69] error_code
    output logic [6:0]  m_tuser,    // [2:0] byte_role, [5:3] major_kind,
                                    // [6] head_complete
    output logic        m_tlast     // item_done
);

    localparam int LVL_W = $clog2(NEST_DEPTH + 1);

    // walk state
    cbw_pkg::phase_t phase_reg, phase_next;
    logic [3:0]  arg_left_reg, arg_left_next;
    logic [63:0] accum_reg, accum_next;
    logic [2:0]  major_reg, major_next;
    logic [63:0] content_reg, content_next;
    logic [2:0]  err_reg, err_next;

    // result register
    logic        m_valid_reg;
    logic [71:0] m_data_reg;
    logic [6:0]  m_user_reg;
    logic        m_last_reg;

    // per-byte decode
    logic        accept;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [4:0]  add;
    logic [63:0] accum_shift;
    logic [2:0]  role;
    logic [2:0]  mk;
    logic        hc;
    logic [63:0] hv;
    logic        fin;
    logic        push_req;
    logic        close_req;
    logic        item_done;

    cbw_pkg::stack_ctrl_t ctrl;
    cbw_pkg::stack_stat_t stat;
    logic [LVL_W-1:0]     level_upd;

    assign data_byte   = s_tdata;
    assign last_byte   = s_tlast;
    assign add         = data_byte[4:0];
    assign accum_shift = {accum_reg[55:0], data_byte};

    // output register frees when taken, so input and output run together
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        role          = cbw_pkg::ROLE_IGNORED;
        mk            = 3'd0;
        hc            = 1'b0;
        hv            = 64'd0;
        fin           = 1'b0;
        push_req      = 1'b0;
        close_req     = 1'b0;
        phase_next    = phase_reg;
        arg_left_next = arg_left_reg;
        accum_next    = accum_reg;
        major_next    = major_reg;
        content_next  = content_reg;
        err_next      = err_reg;

        case (phase_reg)
            cbw_pkg::PH_HEAD:
            begin
                role       = cbw_pkg::ROLE_HEAD;
                mk         = data_byte[7:5];
                major_next = data_byte[7:5];
                if (add >= cbw_pkg::ADD_RESERVED)
                begin
                    // reserved additional value wins over a tag
                    err_next   = cbw_pkg::ERR_RESERVED;
                    phase_next = cbw_pkg::PH_ERROR;
                end
                else if (data_byte[7:5] == cbw_pkg::MAJ_TAG)
                begin
                    err_next   = cbw_pkg::ERR_TAG;
                    phase_next = cbw_pkg::PH_ERROR;
                end
                else if (add < cbw_pkg::ADD_ONE_BYTE)
                begin
                    hc  = 1'b1;
                    hv  = 64'(add);
                    fin = 1'b1;
                end
                else
                begin
                    // 1, 2, 4 or 8 argument bytes follow
                    arg_left_next = 4'd1 << add[1:0];
                    accum_next    = 64'd0;
                    phase_next    = cbw_pkg::PH_ARG;
                end
            end
            cbw_pkg::PH_ARG:
            begin
                role          = cbw_pkg::ROLE_ARG;
                mk            = major_reg;
                accum_next    = accum_shift;
                arg_left_next = arg_left_reg - 4'd1;
                if (arg_left_reg == 4'd1)
                begin
                    hc  = 1'b1;
                    hv  = accum_shift;
                    fin = 1'b1;
                end
            end
            cbw_pkg::PH_CONTENT:
            begin
                role         = cbw_pkg::ROLE_CONTENT;
                mk           = major_reg;
                content_next = content_reg - 64'd1;
                if (content_reg == 64'd1)
                begin
                    close_req = 1'b1;
                end
            end
            cbw_pkg::PH_TRAIL:
            begin
                role = cbw_pkg::ROLE_TRAILING;
            end
            cbw_pkg::PH_ERROR:
            begin
                role = cbw_pkg::ROLE_IGNORED;
            end
            default:
            begin
                role = cbw_pkg::ROLE_IGNORED;
            end
        endcase

        // a completed head: strings load content, containers push, rest close
        if (fin)
        begin
            if ((mk == cbw_pkg::MAJ_BSTR || mk == cbw_pkg::MAJ_TSTR) && hv != 64'd0)
            begin
                content_next = hv;
                phase_next   = cbw_pkg::PH_CONTENT;
            end
            else if ((mk == cbw_pkg::MAJ_ARRAY || mk == cbw_pkg::MAJ_MAP) && hv != 64'd0)
            begin
                if (stat.full)
                begin
                    err_next   = cbw_pkg::ERR_TOO_DEEP;
                    phase_next = cbw_pkg::PH_ERROR;
                end
                else
                begin
                    push_req   = 1'b1;
                    phase_next = cbw_pkg::PH_HEAD;
                end
            end
            else
            begin
                close_req = 1'b1;
            end
        end

        if (close_req)
        begin
            phase_next = stat.done ? cbw_pkg::PH_TRAIL : cbw_pkg::PH_HEAD;
        end

        // buffer ends inside the item
        if (last_byte && (phase_next == cbw_pkg::PH_HEAD || phase_next == cbw_pkg::PH_ARG
                          || phase_next == cbw_pkg::PH_CONTENT))
        begin
            err_next   = cbw_pkg::ERR_TRUNCATED;
            phase_next = cbw_pkg::PH_ERROR;
        end
    end

    assign item_done = stat.done;

    // stack requests only on an accepted transfer
    assign ctrl.push     = accept && push_req;
    assign ctrl.push_map = (mk == cbw_pkg::MAJ_MAP);
    assign ctrl.close    = accept && close_req;
    assign ctrl.flush    = accept && last_byte;

    cbw_stack #(
        .NEST_DEPTH (NEST_DEPTH),
        .LVL_W      (LVL_W)
    ) u_stack (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .push_count (hv),
        .stat       (stat),
        .level_upd  (level_upd)
    );

    // walk state, back to reset after the final byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= cbw_pkg::PH_HEAD;
            arg_left_reg <= 4'd0;
            accum_reg    <= 64'd0;
            major_reg    <= 3'd0;
            content_reg  <= 64'd0;
            err_reg      <= cbw_pkg::ERR_NONE;
        end
        else if (accept)
        begin
            if (last_byte)
            begin
                phase_reg    <= cbw_pkg::PH_HEAD;
                arg_left_reg <= 4'd0;
                accum_reg    <= 64'd0;
                major_reg    <= 3'd0;
                content_reg  <= 64'd0;
                err_reg      <= cbw_pkg::ERR_NONE;
            end
            else
            begin
                phase_reg    <= phase_next;
                arg_left_reg <= arg_left_next;
                accum_reg    <= accum_next;
                major_reg    <= major_next;
                content_reg  <= content_next;
                err_reg      <= err_next;
            end
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_data_reg <= {err_next, 5'(level_upd), hv};
            m_user_reg <= {hc, mk, role};
            m_last_reg <= item_done;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // the top-level item never completes with an error and only on a walked byte
    a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |-> (m_tdata[71:69] == cbw_pkg::ERR_NONE
            && (m_tuser[2:0] == cbw_pkg::ROLE_HEAD || m_tuser[2:0] == cbw_pkg::ROLE_ARG
                || m_tuser[2:0] == cbw_pkg::ROLE_CONTENT)))
        else $error("item done with error or on a trailing byte");

    // a head completes only on a head or argument byte
    a_head_role: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[6]) |-> (m_tuser[2:0] == cbw_pkg::ROLE_HEAD
            || m_tuser[2:0] == cbw_pkg::ROLE_ARG))
        else $error("head complete on wrong byte role");

    // no stack activity once an error or trailing state is reached
    a_idle_stack: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (phase_reg == cbw_pkg::PH_ERROR || phase_reg == cbw_pkg::PH_TRAIL))
            |-> (!ctrl.push && !ctrl.close))
        else $error("stack touched after error or item end");

    // the level follows a push exactly
    a_push_level: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.push && !ctrl.flush) |=> (u_stack.level_reg == $past(level_upd)))
        else $error("stack level lost a push");

endmodule

### src/cbw_cell.sv
// ----------------------------------------------------------------------------
// cbw_cell: one level of the container stack
// holds the open count and map half flag, passes the pop cascade downward
// ----------------------------------------------------------------------------
module cbw_cell #(
    parameter int LVL_W = 5,
    parameter int IDX   = 0
) (
    input  logic                clk,
    input  cbw_pkg::stack_ctrl_t ctrl,
    input  logic [LVL_W-1:0]    level,
    input  logic [63:0]         push_count,
    input  logic                pop_in,     // cell above popped
    output logic                pop_out     // this cell popped
);

    logic [63:0] count_reg, count_next;
    logic        is_map_reg, is_map_next;
    logic        half_reg, half_next;
    logic        is_top;
    logic        push_here;
    logic        close_here;
    logic        finishes;

    assign is_top     = (level == LVL_W'(IDX + 1));
    assign push_here  = ctrl.push && (level == LVL_W'(IDX));
    assign close_here = ctrl.close && (is_top || pop_in);
    // a map key only flips the half flag; otherwise the count runs down
    assign finishes   = !(is_map_reg && !half_reg) && (count_reg == 64'd1);
    assign pop_out    = close_here && finishes;

    always_comb
    begin
        count_next  = count_reg;
        is_map_next = is_map_reg;
        half_next   = half_reg;
        if (push_here)
        begin
            count_next  = push_count;
            is_map_next = ctrl.push_map;
            half_next   = 1'b0;
        end
        else if (close_here && !finishes)
        begin
            if (is_map_reg && !half_reg)
            begin
                half_next = 1'b1;
            end
            else
            begin
                half_next  = 1'b0;
                count_next = count_reg - 64'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        count_reg  <= count_next;
        is_map_reg <= is_map_next;
        half_reg   <= half_next;
    end

endmodule

### src/cbw_stack.sv
// ----------------------------------------------------------------------------
// cbw_stack: row of stack cells with the level counter
// pop cascade ripples from the top cell down through the row
// ----------------------------------------------------------------------------
module cbw_stack #(
    parameter int NEST_DEPTH = cbw_pkg::NEST_DEPTH_DEF,
    parameter int LVL_W      = $clog2(NEST_DEPTH + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cbw_pkg::stack_ctrl_t ctrl,
    input  logic [63:0]          push_count,
    output cbw_pkg::stack_stat_t stat,
    output logic [LVL_W-1:0]     level_upd   // level after this byte, before flush
);

    logic [LVL_W-1:0]  level_reg, level_next;
    logic [NEST_DEPTH:0] pop;
    logic [LVL_W-1:0]  low_pop;

    assign pop[NEST_DEPTH] = 1'b0;

    for (genvar i = 0; i < NEST_DEPTH; i++)
    begin : g_cell
        cbw_cell #(
            .LVL_W (LVL_W),
            .IDX   (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .level      (level_reg),
            .push_count (push_count),
            .pop_in     (pop[i+1]),
            .pop_out    (pop[i])
        );
    end

    // popped cells are contiguous from the top; the lowest one is the new level
    always_comb
    begin
        low_pop = level_reg;
        for (int i = NEST_DEPTH - 1; i >= 0; i--)
        begin
            if (pop[i])
            begin
                low_pop = LVL_W'(i);
            end
        end
    end

    assign stat.full = (level_reg == LVL_W'(NEST_DEPTH));
    assign stat.done = ctrl.close && ((level_reg == '0) || pop[0]);

    always_comb
    begin
        level_upd = level_reg;
        if (ctrl.push)
        begin
            level_upd = level_reg + LVL_W'(1);
        end
        else if (ctrl.close)
        begin
            level_upd = low_pop;
        end
        level_next = ctrl.flush ? '0 : level_upd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
        end
        else
        begin
            level_reg <= level_next;
        end
    end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the cbor item walker
// feeds cbor buffers one byte per transfer, predicts every per-byte result in
// a behavioral walker of its own and checks each output transfer field by
// field; a short directed table comes first, then random buffers
// ----------------------------------------------------------------------------
module tb;

    import cbw_pkg::*;

    localparam int CLK_PERIOD = 4;
    localparam int DEPTH      = NEST_DEPTH_DEF;
    localparam int RAND_BYTES = 1000;      // walked bytes wanted from the random part
    localparam int MAX_CYCLES = 200_000;   // hard stop, far above the slowest legal run
    localparam int HOLD_LEN   = 300;       // long receiver hold-off, fills the block up

    // major types the package leaves unnamed
    localparam logic [2:0] MAJ_UINT   = 3'd0;
    localparam logic [2:0] MAJ_NINT   = 3'd1;
    localparam logic [2:0] MAJ_SIMPLE = 3'd7;

    // one result as the walker reports it
    typedef struct packed {
        logic [2:0]  role;
        logic [2:0]  major;
        logic        head_done;
        logic [63:0] value;
        logic [4:0]  level;
        logic        item_done;
        logic [2:0]  err;
    } walk_result_t;

    // one input byte, with an optional hand-written expectation
    typedef struct packed {
        logic [7:0]   data;
        logic         last;
        logic         typed;
        walk_result_t want;
    } byte_row_t;

    localparam walk_result_t NO_WANT = '0;

    // directed table: extremes, the tag, reserved and truncated errors, ignored and
    // trailing bytes, an empty string and map, a map pair and a float with eight argument bytes
    localparam byte_row_t DIRECTED [23] = '{
        // smallest item, the whole buffer
        '{8'h00, 1'b1, 1'b1, '{ROLE_HEAD, MAJ_UINT, 1'b1, 64'd0, 5'd0, 1'b1, ERR_NONE}},
        // reserved additional value, then a byte ignored after the error
        '{8'hFF, 1'b0, 1'b1, '{ROLE_HEAD, MAJ_SIMPLE, 1'b0, 64'd0, 5'd0, 1'b0, ERR_RESERVED}},
        '{8'h00, 1'b1, 1'b1, '{ROLE_IGNORED, MAJ_UINT, 1'b0, 64'd0, 5'd0, 1'b0, ERR_RESERVED}},
        // tag head
        '{8'hC0, 1'b1, 1'b1, '{ROLE_HEAD, MAJ_TAG, 1'b0, 64'd0, 5'd0, 1'b0, ERR_TAG}},
        // tag with a reserved additional value: reserved wins
        '{8'hDC, 1'b1, 1'b1, '{ROLE_HEAD, MAJ_TAG, 1'b0, 64'd0, 5'd0, 1'b0, ERR_RESERVED}},
        // final byte arrives while the argument is still missing
        '{8'h18, 1'b1, 1'b1, '{ROLE_HEAD, MAJ_UINT, 1'b0, 64'd0, 5'd0, 1'b0, ERR_TRUNCATED}},
        // double float, all-ones argument
        '{8'hFB, 1'b0, 1'b0, NO_WANT},
        '{8'hFF, 1'b0, 1'b0, NO_WANT},
        '{8'hFF, 1'b0, 1'b0, NO_WANT},
        '{8'hFF, 1'b0, 1'b0, NO_WANT},
        '{8'hFF, 1'b0, 1'b0, NO_WANT},
        '{8'hFF, 1'b0, 1'b0, NO_WANT},
        '{8'hFF, 1'b0, 1'b0, NO_WANT},
        '{8'hFF, 1'b0, 1'b0, NO_WANT},
        '{8'hFF, 1'b1, 1'b1, '{ROLE_ARG, MAJ_SIMPLE, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0,
                               1'b1, ERR_NONE}},
        // [h'', {}, {"A": true}] followed by one trailing byte
        '{8'h83, 1'b0, 1'b0, NO_WANT},
        '{8'h40, 1'b0, 1'b0, NO_WANT},
        '{8'hA0, 1'b0, 1'b0, NO_WANT},
        '{8'hA1, 1'b0, 1'b0, NO_WANT},
        '{8'h61, 1'b0, 1'b0, NO_WANT},
        '{8'h41, 1'b0, 1'b0, NO_WANT},
        '{8'hF5, 1'b0, 1'b0, NO_WANT},
        '{8'h00, 1'b1, 1'b0, NO_WANT}
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // [7:0] data_byte
    logic        s_tlast;    // last_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;    // [63:0] head_value, [68:64] nest_level, [71:69] error_code
    logic [6:0]  m_tuser;    // [2:0] byte_role, [5:3] major_kind, [6] head_complete
    logic        m_tlast;    // item_done

    cbor_item_walker #(
        .NEST_DEPTH(DEPTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // behavioral walker: state of its own, advanced once per accepted byte
    // ------------------------------------------------------------------
    phase_t      walk_ph;
    int          arg_left;
    logic [63:0] arg_value;
    logic [2:0]  cur_major;
    logic [63:0] content_left;
    logic [63:0] open_cnt [DEPTH];
    logic        pair_second [DEPTH];   // map is waiting for the value of a pair
    logic        open_map [DEPTH];
    int          lvl;
    logic [2:0]  err_held;

    function automatic void clear_walk();
        walk_ph      = PH_HEAD;
        arg_left     = 0;
        arg_value    = '0;
        cur_major    = MAJ_UINT;
        content_left = '0;
        lvl          = 0;
        err_held     = ERR_NONE;
    endfunction

    // a child item finished: close every container it completes,
    // true once the top-level item is over
    function automatic logic close_child();
        int t;
        while (lvl > 0) begin
            t = lvl - 1;
            if (open_map[t] && !pair_second[t]) begin
                pair_second[t] = 1'b1;
                return 1'b0;
            end
            pair_second[t] = 1'b0;
            open_cnt[t] -= 64'd1;
            if (open_cnt[t] != 0)
                return 1'b0;
            lvl--;
        end
        return 1'b1;
    endfunction

    // head of major type mj with argument v is complete
    function automatic logic head_finished(logic [2:0] mj, logic [63:0] v);
        logic done;
        if ((mj == MAJ_BSTR || mj == MAJ_TSTR) && v != 0) begin
            content_left = v;
            walk_ph      = PH_CONTENT;
            return 1'b0;
        end
        if ((mj == MAJ_ARRAY || mj == MAJ_MAP) && v != 0) begin
            if (lvl >= DEPTH) begin
                err_held = ERR_TOO_DEEP;
                walk_ph  = PH_ERROR;
                return 1'b0;
            end
            open_cnt[lvl]    = v;
            pair_second[lvl] = 1'b0;
            open_map[lvl]    = (mj == MAJ_MAP);
            lvl++;
            walk_ph = PH_HEAD;
            return 1'b0;
        end
        // scalar, or empty string / container: nothing is pushed
        done    = close_child();
        walk_ph = done ? PH_TRAIL : PH_HEAD;
        return done;
    endfunction

    function automatic walk_result_t walk_byte(logic [7:0] b, logic last);
        walk_result_t r;
        logic [4:0]   add;
        r   = '0;
        add = b[4:0];
        case (walk_ph)
            PH_HEAD: begin
                r.role    = ROLE_HEAD;
                r.major   = b[7:5];
                cur_major = b[7:5];
                if (add >= ADD_RESERVED) begin
                    err_held = ERR_RESERVED;
                    walk_ph  = PH_ERROR;
                end else if (r.major == MAJ_TAG) begin
                    err_held = ERR_TAG;
                    walk_ph  = PH_ERROR;
                end else if (add < ADD_ONE_BYTE) begin
                    r.head_done = 1'b1;
                    r.value     = {59'd0, add};
                    r.item_done = head_finished(r.major, r.value);
                end else begin
                    arg_left  = 1 << (add - ADD_ONE_BYTE);
                    arg_value = '0;
                    walk_ph   = PH_ARG;
                end
            end
            PH_ARG: begin
                r.role    = ROLE_ARG;
                r.major   = cur_major;
                arg_value = {arg_value[55:0], b};
                if (arg_left != 0)
                    arg_left--;
                if (arg_left == 0) begin
                    r.head_done = 1'b1;
                    r.value     = arg_value;
                    r.item_done = head_finished(cur_major, arg_value);
                end
            end
            PH_CONTENT: begin
                r.role  = ROLE_CONTENT;
                r.major = cur_major;
                if (content_left != 0)
                    content_left--;
                if (content_left == 0) begin
                    r.item_done = close_child();
                    walk_ph     = r.item_done ? PH_TRAIL : PH_HEAD;
                end
            end
            PH_TRAIL: r.role = ROLE_TRAILING;
            default:  r.role = ROLE_IGNORED;
        endcase
        // buffer ends inside the item
        if (last && (walk_ph == PH_HEAD || walk_ph == PH_ARG || walk_ph == PH_CONTENT)) begin
            err_held = ERR_TRUNCATED;
            walk_ph  = PH_ERROR;
        end
        r.level = lvl[4:0];
        r.err   = err_held;
        if (last)
            clear_walk();
        return r;
    endfunction

    // ------------------------------------------------------------------
    // random cbor buffers
    // ------------------------------------------------------------------
    logic [7:0] buf_q [$];

    // form 0 puts the argument in the head byte, forms 1..4 use 1, 2, 4, 8 bytes
    function automatic void put_head(logic [2:0] mj, logic [63:0] v, int form);
        logic [4:0] add;
        int         n;
        if (form == 0) begin
            buf_q.push_back({mj, v[4:0]});
        end else begin
            add = ADD_ONE_BYTE + 5'(form - 1);
            n   = 1 << (form - 1);
            buf_q.push_back({mj, add});
            for (int i = n - 1; i >= 0; i--)
                buf_q.push_back(v[8 * i +: 8]);
        end
    endfunction

    function automatic logic [63:0] rand_arg(int form);
        logic [63:0] v;
        v = {$urandom, $urandom};
        case (form)
            0:       v = 64'($urandom_range(0, 23));
            1:       v = {56'd0, v[7:0]};
            2:       v = {48'd0, v[15:0]};
            3:       v = {32'd0, v[31:0]};
            default: if ($urandom_range(0, 3) == 0) v = '1;
        endcase
        return v;
    endfunction

    // one well-formed item with random content; lengths stay small but may
    // still be spelled with long argument forms
    function automatic void gen_item(int depth);
        int         pick;
        int         n;
        int         form;
        logic [2:0] mj;
        pick = $urandom_range(0, 9);
        form = $urandom_range(0, 4);
        if (depth >= 2 && pick >= 6)
            pick = $urandom_range(0, 5);
        if (pick <= 2) begin
            mj = (pick == 0) ? MAJ_UINT : (pick == 1) ? MAJ_NINT : MAJ_SIMPLE;
            put_head(mj, rand_arg(form), form);
        end else if (pick <= 5) begin
            n = $urandom_range(0, 3);
            put_head($urandom_range(0, 1) ? MAJ_TSTR : MAJ_BSTR, 64'(n), form);
            repeat (n) buf_q.push_back(8'($urandom));
        end else if (pick <= 7) begin
            n = $urandom_range(0, 3);
            put_head(MAJ_ARRAY, 64'(n), form);
            repeat (n) gen_item(depth + 1);
        end else begin
            n = $urandom_range(0, 2);
            put_head(MAJ_MAP, 64'(n), form);
            repeat (2 * n) gen_item(depth + 1);
        end
    endfunction

    // ------------------------------------------------------------------
    // sender: bursts of random length with random gaps between them
    // ------------------------------------------------------------------
    byte_row_t    stim_q [$];
    walk_result_t exp_q [$];      // expected results, oldest first
    byte_row_t    cur_row;
    walk_result_t predicted;
    bit           steady;         // no random gaps or stalls while set, long hold-offs apart
    int           burst_left;
    int           gap_left;
    int           n_accepted;
    int           n_walked;       // accepted bytes that were part of an item
    int           n_items_done;
    int           max_level;
    int           err_hist [8];

    always @(posedge clk) begin
        if (rst_n) begin
            if (s_tvalid && s_tready) begin
                predicted = walk_byte(cur_row.data, cur_row.last);
                exp_q.push_back(cur_row.typed ? cur_row.want : predicted);
                n_accepted++;
                if (predicted.role < ROLE_TRAILING)
                    n_walked++;
                if (predicted.item_done)
                    n_items_done++;
                if (int'(predicted.level) > max_level)
                    max_level = predicted.level;
                if (cur_row.last)
                    err_hist[predicted.err]++;
            end
            // the slot is free when nothing is offered or the offer just went
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (stim_q.size() > 0) begin
                    cur_row = stim_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= cur_row.data;
                    s_tlast  <= cur_row.last;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 15);
                        gap_left   = steady ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: ready runs and stalls of its own length, plus two long
    // hold-offs that back the block up into its input
    // ------------------------------------------------------------------
    int rx_seen;
    int hold_left;
    int holds_taken;
    int ready_run;
    int stall_run;

    always @(posedge clk) begin
        if (rst_n) begin
            if (m_tvalid && m_tready)
                rx_seen++;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (holds_taken < 2 && rx_seen >= 200 + 400 * holds_taken) begin
                holds_taken++;
                hold_left = HOLD_LEN;
                m_tready <= 1'b0;
            end else if (steady) begin
                m_tready <= 1'b1;
            end else if (ready_run > 0) begin
                ready_run--;
                m_tready <= 1'b1;
            end else if (stall_run > 0) begin
                stall_run--;
                m_tready <= 1'b0;
            end else begin
                ready_run = $urandom_range(1, 20);
                stall_run = $urandom_range(0, 4);
                m_tready <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------
    int           n_errors;
    walk_result_t oldest;

    task automatic check_field(input string what, input logic [63:0] want, input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
            n_errors++;
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) begin
            if (exp_q.size() == 0) begin
                $display("%0t: result transfer with nothing expected, tdata 0x%0h tuser 0x%0h",
                         $time, m_tdata, m_tuser);
                n_errors++;
            end else begin
                oldest = exp_q.pop_front();
                check_field("byte_role",     oldest.role,      m_tuser[2:0]);
                check_field("major_kind",    oldest.major,     m_tuser[5:3]);
                check_field("head_complete", oldest.head_done, m_tuser[6]);
                check_field("head_value",    oldest.value,     m_tdata[63:0]);
                check_field("nest_level",    oldest.level,     m_tdata[68:64]);
                check_field("item_done",     oldest.item_done, m_tlast);
                check_field("error_code",    oldest.err,       m_tdata[71:69]);
            end
        end
    end

    // watchdog
    int cycles;

    always @(posedge clk) begin
        cycles++;
        if (cycles > MAX_CYCLES) begin
            $display("%0t: run did not finish within %0d cycles", $time, MAX_CYCLES);
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus; the queue is only touched at the falling edge so that the
    // sender sees it settled at every rising edge
    // ------------------------------------------------------------------
    initial begin
        int        kind;
        int        cut;
        int        n;
        int        walked_base;
        int        n_buffers;
        logic [7:0] bad;
        byte_row_t row;
        bit        map_lvl [$];

        clk      = 1'b0;
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tlast  = 1'b0;
        m_tready = 1'b0;
        steady   = 1'b0;
        n_buffers = 0;
        clear_walk();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        foreach (DIRECTED[i])
            stim_q.push_back(DIRECTED[i]);
        while (stim_q.size() > 0) @(negedge clk);
        walked_base = n_walked;

        // random buffers, each closed by a final byte
        while (n_walked - walked_base < RAND_BYTES) begin
            while (stim_q.size() >= 8) @(negedge clk);
            buf_q.delete();
            steady = ($urandom_range(0, 7) == 0);
            kind   = $urandom_range(0, 99);
            if (kind < 65) begin
                // well-formed item, maybe followed by trailing bytes
                gen_item(0);
                repeat ($urandom_range(0, 2)) buf_q.push_back(8'($urandom));
            end else if (kind < 77) begin
                // item cut short
                gen_item(0);
                cut = $urandom_range(1, buf_q.size());
                while (buf_q.size() > cut) void'(buf_q.pop_back());
            end else if (kind < 85) begin
                // raw noise
                repeat ($urandom_range(1, 6)) buf_q.push_back(8'($urandom));
            end else if (kind < 93) begin
                // one-element arrays and maps nested around the stack limit
                n = $urandom_range(DEPTH - 2, DEPTH + 2);
                map_lvl.delete();
                repeat (n) begin
                    map_lvl.push_back($urandom_range(0, 1));
                    put_head(map_lvl[$] ? MAJ_MAP : MAJ_ARRAY, 64'd1, 0);
                end
                put_head(MAJ_UINT, 64'($urandom_range(0, 23)), 0);
                while (map_lvl.size() > 0)
                    if (map_lvl.pop_back())
                        put_head(MAJ_UINT, 64'd0, 0);   // the value of the pair
            end else begin
                // tag or reserved byte dropped somewhere into an item
                gen_item(0);
                if ($urandom_range(0, 1))
                    bad = {MAJ_TAG, 5'($urandom)};
                else
                    bad = {3'($urandom), 5'($urandom_range(28, 31))};
                buf_q.insert($urandom_range(0, buf_q.size()), bad);
            end
            foreach (buf_q[i]) begin
                row.data  = buf_q[i];
                row.last  = (i == buf_q.size() - 1);
                row.typed = 1'b0;
                row.want  = NO_WANT;
                stim_q.push_back(row);
            end
            n_buffers++;
        end

        // drain: everything offered, everything checked, then a short tail
        // in which a stray result would still be caught
        while (stim_q.size() > 0 || s_tvalid) @(negedge clk);
        while (exp_q.size() > 0) @(negedge clk);
        repeat (20) @(negedge clk);

        $display("walked %0d random buffers and the directed table: %0d bytes, %0d items done,",
                 n_buffers, n_accepted, n_items_done);
        $display("deepest nesting %0d; buffers ending in tag %0d, reserved %0d, truncated %0d, too deep %0d",
                 max_level, err_hist[ERR_TAG], err_hist[ERR_RESERVED],
                 err_hist[ERR_TRUNCATED], err_hist[ERR_TOO_DEEP]);
        if (n_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### filelist.f
src/cbw_pkg.sv
src/cbw_cell.sv
src/cbw_stack.sv
src/cbor_item_walker.sv
sim/tb.sv
